// ----- rtl/qeve_pkg.sv -----
// Package for the quadrature edge velocity estimator.
// Holds the shared widths, codes, state type and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qeve_pkg;

   localparam int TIME_W     = 32;
   localparam int DIST_W     = 20;
   localparam int VEL_W      = 32;
   localparam int TOTAL_W    = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 88;

   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_TICK = 1'b1;
   localparam logic CHAN_A   = 1'b0;
   localparam logic CHAN_B   = 1'b1;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd100000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DUAL_TRIGGER   = 3'd0,
      REG_STEP_NM        = 3'd1,
      REG_A_TO_B_FWD_NM  = 3'd2,
      REG_B_TO_A_FWD_NM  = 3'd3,
      REG_A_TO_B_BACK_NM = 3'd4,
      REG_B_TO_A_BACK_NM = 3'd5,
      REG_BOTH_WAYS      = 3'd6,
      REG_TIMEOUT_US     = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_CALC   = 2'd1,
      ST_DIVIDE = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic tick;
      logic skip;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/qeve_ctrl.sv -----
// Controller state machine of the quadrature edge velocity estimator.
// Sequences accept, accumulate, serial divide and result load; uses qeve_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qeve_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  qeve_pkg::dp_status_type status,
   output qeve_pkg::dp_cmd_type    cmd
);

   qeve_pkg::state_type state_ff;
   qeve_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qeve_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         qeve_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = qeve_pkg::ST_CALC;
            end
         end
         qeve_pkg::ST_CALC: begin
            cmd.calc = 1'b1;
            if (status.tick || status.skip) begin
               state_in = qeve_pkg::ST_FINISH;
            end else begin
               state_in = qeve_pkg::ST_DIVIDE;
            end
         end
         qeve_pkg::ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = qeve_pkg::ST_FINISH;
            end
         end
         qeve_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = qeve_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qeve_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/qeve_datapath.sv -----
// Datapath of the quadrature edge velocity estimator: settings, tracking state,
// distance accumulator, restoring divider and result register. Uses qeve_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qeve_datapath #(
   parameter int VEL_FRAC_BITS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire  [qeve_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [qeve_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire  [qeve_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [qeve_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  qeve_pkg::dp_cmd_type                 cmd,
   output qeve_pkg::dp_status_type              status
);

   localparam int DW = qeve_pkg::DIST_W + VEL_FRAC_BITS;
   localparam int QW = (DW > 33) ? DW : 33;
   localparam int CW = $clog2(DW + 1);

   logic                          dual_ff;
   logic [qeve_pkg::DIST_W-1:0]   step_nm_ff;
   logic [qeve_pkg::DIST_W-1:0]   a2b_fwd_ff;
   logic [qeve_pkg::DIST_W-1:0]   b2a_fwd_ff;
   logic [qeve_pkg::DIST_W-1:0]   a2b_back_ff;
   logic [qeve_pkg::DIST_W-1:0]   b2a_back_ff;
   logic                          both_ways_ff;
   logic [qeve_pkg::TIME_W-1:0]   timeout_ff;

   logic [qeve_pkg::TIME_W-1:0]   last_time_ff;
   logic                          last_fwd_ff;
   logic                          last_rev_ff;
   logic [qeve_pkg::VEL_W-1:0]    speed_ff;
   logic [qeve_pkg::TOTAL_W-1:0]  total_ff;

   logic                          tick_ff;
   logic [qeve_pkg::TIME_W-1:0]   now_ff;
   logic [qeve_pkg::TIME_W-1:0]   elapsed_ff;
   logic [qeve_pkg::DIST_W-1:0]   mag_ff;
   logic                          neg_ff;

   logic [qeve_pkg::TIME_W-1:0]   rem_ff;
   logic [DW-1:0]                 quo_ff;
   logic [CW-1:0]                 cnt_ff;

   logic                          rsp_valid_ff;
   logic [qeve_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic                          in_chan;
   logic                          in_la;
   logic                          in_lb;
   logic [qeve_pkg::TIME_W-1:0]   in_time;
   logic                          in_fwd;
   logic                          in_rev;
   logic [qeve_pkg::DIST_W-1:0]   in_mag;

   logic [32:0]                   trial;
   logic [qeve_pkg::DIST_W:0]     step_s;
   logic [qeve_pkg::TOTAL_W:0]    sum;
   logic [qeve_pkg::TOTAL_W-1:0]  total_in;
   logic [QW-1:0]                 q_ext;
   logic [qeve_pkg::VEL_W-1:0]    vel_in;
   logic [qeve_pkg::VEL_W-1:0]    speed_in;
   logic                          timed_out;

   assign in_chan = req_tdata[0];
   assign in_la   = req_tdata[1];
   assign in_lb   = req_tdata[2];
   assign in_time = req_tdata[34:3];

   always_comb begin
      if (in_la == in_lb) begin
         in_fwd = (in_chan == qeve_pkg::CHAN_B);
      end else begin
         in_fwd = (in_chan == qeve_pkg::CHAN_A);
      end
      in_rev = (in_fwd != last_fwd_ff);
      if (in_rev) begin
         in_mag = '0;
      end else if (!dual_ff) begin
         in_mag = step_nm_ff;
      end else if (in_chan == qeve_pkg::CHAN_A) begin
         in_mag = in_fwd ? a2b_fwd_ff : b2a_back_ff;
      end else begin
         in_mag = in_fwd ? b2a_fwd_ff : a2b_back_ff;
      end
   end

   // Settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dual_ff      <= 1'b1;
         step_nm_ff   <= '0;
         a2b_fwd_ff   <= '0;
         b2a_fwd_ff   <= '0;
         a2b_back_ff  <= '0;
         b2a_back_ff  <= '0;
         both_ways_ff <= 1'b1;
         timeout_ff   <= qeve_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         case (qeve_pkg::reg_index_type'(csr_index))
            qeve_pkg::REG_DUAL_TRIGGER:   dual_ff      <= csr_wdata[0];
            qeve_pkg::REG_STEP_NM:        step_nm_ff   <= csr_wdata[qeve_pkg::DIST_W-1:0];
            qeve_pkg::REG_A_TO_B_FWD_NM:  a2b_fwd_ff   <= csr_wdata[qeve_pkg::DIST_W-1:0];
            qeve_pkg::REG_B_TO_A_FWD_NM:  b2a_fwd_ff   <= csr_wdata[qeve_pkg::DIST_W-1:0];
            qeve_pkg::REG_A_TO_B_BACK_NM: a2b_back_ff  <= csr_wdata[qeve_pkg::DIST_W-1:0];
            qeve_pkg::REG_B_TO_A_BACK_NM: b2a_back_ff  <= csr_wdata[qeve_pkg::DIST_W-1:0];
            qeve_pkg::REG_BOTH_WAYS:      both_ways_ff <= csr_wdata[0];
            qeve_pkg::REG_TIMEOUT_US:     timeout_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Item capture and edge tracking state.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         last_fwd_ff  <= 1'b1;
         last_rev_ff  <= 1'b0;
      end else if (cmd.load && (req_tuser == qeve_pkg::CMD_EDGE)) begin
         last_time_ff <= in_time;
         last_fwd_ff  <= in_fwd;
         last_rev_ff  <= in_rev;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tick_ff    <= (req_tuser == qeve_pkg::CMD_TICK);
         now_ff     <= in_time;
         elapsed_ff <= in_time - last_time_ff;
         mag_ff     <= in_mag;
         neg_ff     <= !in_fwd;
      end
   end

   // Saturating distance accumulator.
   always_comb begin
      step_s = neg_ff ? (~{1'b0, mag_ff} + 1'b1) : {1'b0, mag_ff};
      sum    = {total_ff[qeve_pkg::TOTAL_W-1], total_ff}
             + {{(qeve_pkg::TOTAL_W - qeve_pkg::DIST_W){step_s[qeve_pkg::DIST_W]}}, step_s};
      if (sum[qeve_pkg::TOTAL_W] != sum[qeve_pkg::TOTAL_W-1]) begin
         total_in = {sum[qeve_pkg::TOTAL_W], {(qeve_pkg::TOTAL_W-1){!sum[qeve_pkg::TOTAL_W]}}};
      end else begin
         total_in = sum[qeve_pkg::TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.calc && !tick_ff && (both_ways_ff || !neg_ff)) begin
         total_ff <= total_in;
      end
   end

   // Restoring divider, one quotient bit per cycle.
   assign trial = {rem_ff, quo_ff[DW-1]} - {1'b0, elapsed_ff};

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         rem_ff <= '0;
         quo_ff <= DW'(mag_ff) << VEL_FRAC_BITS;
         cnt_ff <= CW'(DW);
      end else if (cmd.step) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[DW-1]};
         end
         quo_ff <= {quo_ff[DW-2:0], !trial[32]};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // Velocity with saturation, and the tick timeout check.
   always_comb begin
      q_ext = QW'(quo_ff);
      if (mag_ff == '0) begin
         vel_in = '0;
      end else if (elapsed_ff == '0) begin
         vel_in = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (|q_ext[QW-1:31]) begin
         vel_in = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         vel_in = neg_ff ? (~q_ext[31:0] + 1'b1) : q_ext[31:0];
      end
      timed_out = (now_ff > last_time_ff) && ((now_ff - last_time_ff) > timeout_ff);
      if (tick_ff) begin
         speed_in = timed_out ? '0 : speed_ff;
      end else begin
         speed_in = vel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
      end else if (cmd.finish) begin
         speed_ff <= speed_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= {6'd0, last_rev_ff, last_fwd_ff, total_ff, speed_in};
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.tick     = tick_ff;
   assign status.skip     = (mag_ff == '0) || (elapsed_ff == '0);
   assign status.div_last = (cnt_ff == CW'(1));
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

// ----- rtl/quadrature_edge_velocity_estimator.sv -----
// Sequence: an edge beat passes from accept through the calc, divide and finish
// states, the divide state running the one-bit-per-cycle restoring divider; a tick beat,
// or an edge with zero distance or zero elapsed time, skips the divider.
// Throughput: one beat at a time; the next beat is accepted once the result is
// loaded into the output register, and the finish state waits while an earlier
// result still waits on rsp_tready. Reset is synchronous,
// active high, and restores all settings and tracking state to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_edge_velocity_estimator #(
   parameter int VEL_FRAC_BITS = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire  [qeve_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [qeve_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // edge_channel, level_a, level_b, time_us[31:0], zero pad
   input  wire  [qeve_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command
   input  wire                                req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // velocity[31:0], total_nm[47:0], moving_forward, reversed, zero pad
   output logic [qeve_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   qeve_pkg::dp_cmd_type    cmd;
   qeve_pkg::dp_status_type status;

   qeve_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   qeve_datapath #(
      .VEL_FRAC_BITS (VEL_FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

// ----- rtl/qeve_checker.sv -----
// Port-level checker for the quadrature edge velocity estimator, bound to the top.
// Depends on qeve_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none

module qeve_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [qeve_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result beat changed or dropped while stalled.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Second beat accepted while one is in work.");

   a_result_frees_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("Input not ready when a new result appears.");

endmodule

bind quadrature_edge_velocity_estimator qeve_checker u_qeve_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
